/* rtl/rps_pkg.sv */
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types, codes and widths for the ramped pulse sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

  localparam int WIDTH_W              = 24;
  localparam int RAMP_W               = 25;
  localparam int COUNT_W              = 32;
  localparam int RUNS_W               = 32;
  localparam int GAP_MS_W             = 16;
  localparam int CFG_IDX_W            = 3;
  localparam int CFG_DATA_W           = 32;
  localparam int DEFAULT_TICKS_PER_MS = 1000;

  localparam logic [WIDTH_W-1:0] START_WIDTH_RST = WIDTH_W'(1);
  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST   = WIDTH_W'(1);
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST   = {WIDTH_W{1'b1}};

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG,
    PH_DELAY,
    PH_PULSE,
    PH_GAP
  } phase_t;

  typedef enum logic [1:0] {
    FN_TICK   = 2'd0,
    FN_ARM    = 2'd1,
    FN_FIRE   = 2'd2,
    FN_DISARM = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_ARMED = 2'd1,
    ST_BAD_WIDTH = 2'd2,
    ST_BUSY      = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_TICKS  = 3'd0,
    REG_START_WIDTH  = 3'd1,
    REG_PULSE_COUNT  = 3'd2,
    REG_RAMP_STEP    = 3'd3,
    REG_GAP_MS       = 3'd4,
    REG_TRIGGER_MODE = 3'd5,
    REG_MIN_WIDTH    = 3'd6,
    REG_MAX_WIDTH    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]       delay_ticks;
    logic [WIDTH_W-1:0]       start_width;
    logic [COUNT_W-1:0]       pulse_count;
    logic signed [RAMP_W-1:0] ramp_step;
    logic                     trigger_mode;
    logic [WIDTH_W-1:0]       min_width;
    logic [WIDTH_W-1:0]       max_width;
  } cfg_t;

  typedef struct packed {
    logic              power_enable;
    logic              armed_flag;
    logic              busy_res;
    logic              run_done;
    status_t           status;
    logic [RUNS_W-1:0] runs_completed;
  } res_t;

endpackage

`default_nettype wire

/* rtl/rps_seq.sv */
// ----------------------------------------------------------------------------
// rps_seq
// Sequencer state: arm/fire/disarm handling, phase timing, width ramp.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_seq
  import rps_pkg::*;
#(
  parameter int CNT_W = 26
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire func_t            func,
  input  wire logic             ext_trigger,
  input  wire cfg_t             cfg,
  input  wire logic [CNT_W-1:0] gap_ticks,
  output res_t                  res
);

  typedef struct packed {
    phase_t           ph;
    logic [CNT_W-1:0] cnt;
  } step_t;

  localparam int SUM_W = WIDTH_W + 3;

  phase_t              phase, phase_next;
  logic [CNT_W-1:0]    phase_counter, phase_counter_next;
  logic [WIDTH_W-1:0]  current_width, current_width_next;
  logic [COUNT_W-1:0]  pulses_left, pulses_left_next;
  logic [RUNS_W-1:0]   run_count, run_count_next;
  logic                armed, armed_next;
  logic                done_now;
  status_t             status_now;

  logic [CNT_W-1:0]    cnt_dec;
  logic [COUNT_W-1:0]  pl_dec;
  logic signed [SUM_W-1:0] w_sum;
  logic signed [SUM_W-1:0] w_lo;
  logic [WIDTH_W-1:0]  w_ramp;
  logic                slot_end;
  logic [WIDTH_W-1:0]  slot_w;
  step_t               st;

  function automatic step_t f_pulse(logic [WIDTH_W-1:0] w);
    step_t s;
    s.ph  = PH_PULSE;
    s.cnt = (w == '0) ? CNT_W'(1) : CNT_W'(w);
    return s;
  endfunction

  function automatic step_t f_delay(cfg_t c, logic [WIDTH_W-1:0] w);
    step_t s;
    if (c.delay_ticks == '0) begin
      s = f_pulse(w);
    end else begin
      s.ph  = PH_DELAY;
      s.cnt = CNT_W'(c.delay_ticks);
    end
    return s;
  endfunction

  function automatic step_t f_start(cfg_t c, logic [WIDTH_W-1:0] w);
    step_t s;
    if (c.trigger_mode) begin
      s.ph  = PH_TRIG;
      s.cnt = '0;
    end else begin
      s = f_delay(c, w);
    end
    return s;
  endfunction

  assign cnt_dec = phase_counter - CNT_W'(1);
  assign pl_dec  = pulses_left - COUNT_W'(1);

  // ramp at full precision, clamp low first, then high on the clamped value
  always_comb begin
    w_sum = $signed({3'b000, current_width})
          + $signed({{(SUM_W-RAMP_W){cfg.ramp_step[RAMP_W-1]}}, cfg.ramp_step});
    if (w_sum < $signed({3'b000, cfg.min_width})) begin
      w_lo = $signed({3'b000, cfg.min_width});
    end else begin
      w_lo = w_sum;
    end
    if (w_lo > $signed({3'b000, cfg.max_width})) begin
      w_ramp = cfg.max_width;
    end else begin
      w_ramp = w_lo[WIDTH_W-1:0];
    end
  end

  // next state
  always_comb begin
    phase_next         = phase;
    phase_counter_next = phase_counter;
    current_width_next = current_width;
    pulses_left_next   = pulses_left;
    run_count_next     = run_count;
    armed_next         = armed;
    done_now           = 1'b0;
    status_now         = ST_OK;
    slot_end           = 1'b0;
    slot_w             = current_width;
    st                 = '{ph: phase, cnt: phase_counter};

    if (accept) begin
      if (func == FN_TICK) begin
        unique case (phase)
          PH_TRIG: begin
            if (ext_trigger) begin
              st = f_delay(cfg, current_width);
              phase_next         = st.ph;
              phase_counter_next = st.cnt;
            end
          end
          PH_DELAY: begin
            phase_counter_next = cnt_dec;
            if (cnt_dec == '0) begin
              st = f_pulse(current_width);
              phase_next         = st.ph;
              phase_counter_next = st.cnt;
            end
          end
          PH_PULSE: begin
            phase_counter_next = cnt_dec;
            if (cnt_dec == '0) begin
              current_width_next = w_ramp;
              if (gap_ticks == '0) begin
                slot_end = 1'b1;
                slot_w   = w_ramp;
              end else begin
                phase_next         = PH_GAP;
                phase_counter_next = gap_ticks;
              end
            end
          end
          PH_GAP: begin
            phase_counter_next = cnt_dec;
            if (cnt_dec == '0) begin
              slot_end = 1'b1;
            end
          end
          PH_IDLE: ;
          default: ;
        endcase

        if (slot_end) begin
          pulses_left_next = pl_dec;
          if (pl_dec == '0) begin
            phase_next         = PH_IDLE;
            phase_counter_next = '0;
            run_count_next     = run_count + RUNS_W'(1);
            done_now           = 1'b1;
          end else begin
            st = f_start(cfg, slot_w);
            phase_next         = st.ph;
            phase_counter_next = st.cnt;
          end
        end
      end else if (phase != PH_IDLE) begin
        status_now = ST_BUSY;
      end else begin
        unique case (func)
          FN_ARM: begin
            if (cfg.start_width < cfg.min_width || cfg.start_width > cfg.max_width) begin
              status_now = ST_BAD_WIDTH;
            end else begin
              armed_next = 1'b1;
            end
          end
          FN_FIRE: begin
            if (!armed) begin
              status_now = ST_NOT_ARMED;
            end else begin
              pulses_left_next   = (cfg.pulse_count == '0) ? COUNT_W'(1) : cfg.pulse_count;
              current_width_next = cfg.start_width;
              st = f_start(cfg, cfg.start_width);
              phase_next         = st.ph;
              phase_counter_next = st.cnt;
            end
          end
          FN_DISARM: armed_next = 1'b0;
          default: ;
        endcase
      end
    end
  end

  // result reflects the state after this transaction
  always_comb begin
    res.power_enable   = (phase_next != PH_PULSE);
    res.armed_flag     = armed_next;
    res.busy_res       = (phase_next != PH_IDLE);
    res.run_done       = done_now;
    res.status         = status_now;
    res.runs_completed = run_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_counter <= '0;
      current_width <= '0;
      pulses_left   <= '0;
      run_count     <= '0;
      armed         <= 1'b0;
    end else begin
      phase         <= phase_next;
      phase_counter <= phase_counter_next;
      current_width <= current_width_next;
      pulses_left   <= pulses_left_next;
      run_count     <= run_count_next;
      armed         <= armed_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/ramped_pulse_sequencer.sv */
// ----------------------------------------------------------------------------
// ramped_pulse_sequencer
// Microsecond-tick pulse sequencer with ramped, clamped pulse widths.
// ----------------------------------------------------------------------------
// Each input transaction (tick, arm, fire or disarm) yields exactly one result
// transaction. One input is taken every clock cycle unless the skid entry is full;
// the result is registered in the output register, or in the skid entry while the
// output is stalled. The sequencer's new state is computed combinationally (counter
// decrement, 27-bit ramp add and clamp), and a two-entry output buffer lets input
// keep flowing while the output is stalled; input stalls only when both entries
// are full. The gap length is precomputed as gap_ms * TICKS_PER_MS when gap_ms is
// written. No clearing pass after reset.
`default_nettype none

module ramped_pulse_sequencer
  import rps_pkg::*;
#(
  parameter int TICKS_PER_MS = DEFAULT_TICKS_PER_MS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            func,
  input  wire logic                  ext_trigger,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       power_enable,
  output logic                       armed_flag,
  output logic                       busy_res,
  output logic                       run_done,
  output logic [1:0]                 status,
  output logic [RUNS_W-1:0]          runs_completed,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam longint GAP_MAX = longint'((1 << GAP_MS_W) - 1) * longint'(TICKS_PER_MS);
  localparam int     GAP_W   = $clog2(GAP_MAX + 1);
  localparam int     CNT_W   = (GAP_W > WIDTH_W) ? GAP_W : WIDTH_W;

  cfg_t             cfg;
  logic [CNT_W-1:0] gap_ticks;
  logic             accept;
  res_t             res;

  res_t             o_res, s_res;
  logic             o_valid, s_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_ticks  <= '0;
      cfg.start_width  <= START_WIDTH_RST;
      cfg.pulse_count  <= '0;
      cfg.ramp_step    <= '0;
      cfg.trigger_mode <= 1'b0;
      cfg.min_width    <= MIN_WIDTH_RST;
      cfg.max_width    <= MAX_WIDTH_RST;
      gap_ticks        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_DELAY_TICKS:  cfg.delay_ticks  <= cfg_data[WIDTH_W-1:0];
        REG_START_WIDTH:  cfg.start_width  <= cfg_data[WIDTH_W-1:0];
        REG_PULSE_COUNT:  cfg.pulse_count  <= cfg_data[COUNT_W-1:0];
        REG_RAMP_STEP:    cfg.ramp_step    <= signed'(cfg_data[RAMP_W-1:0]);
        REG_GAP_MS:       gap_ticks        <= CNT_W'(cfg_data[GAP_MS_W-1:0])
                                              * CNT_W'(TICKS_PER_MS);
        REG_TRIGGER_MODE: cfg.trigger_mode <= cfg_data[0];
        REG_MIN_WIDTH:    cfg.min_width    <= cfg_data[WIDTH_W-1:0];
        REG_MAX_WIDTH:    cfg.max_width    <= cfg_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !s_valid;
  assign accept   = in_valid && in_ready;

  rps_seq #(
    .CNT_W(CNT_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .func       (func_t'(func)),
    .ext_trigger(ext_trigger),
    .cfg        (cfg),
    .gap_ticks  (gap_ticks),
    .res        (res)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (!o_valid || out_ready) begin
      if (s_valid) begin
        o_valid <= 1'b1;
        s_valid <= 1'b0;
      end else begin
        o_valid <= accept;
      end
    end else if (accept) begin
      s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || out_ready) begin
      o_res <= s_valid ? s_res : res;
    end
    if (accept && o_valid && !out_ready) begin
      s_res <= res;
    end
  end

  assign out_valid      = o_valid;
  assign power_enable   = o_res.power_enable;
  assign armed_flag     = o_res.armed_flag;
  assign busy_res       = o_res.busy_res;
  assign run_done       = o_res.run_done;
  assign status         = o_res.status;
  assign runs_completed = o_res.runs_completed;

  a_pulse_is_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !power_enable |-> busy_res)
    else $error("pulse reported outside a run");

  a_done_is_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_done |-> !busy_res && status == ST_OK)
    else $error("run end reported while busy or with error status");

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> o_valid)
    else $error("skid entry holds data while output register is empty");

  a_stalled_accept_kept: assert property (@(posedge clk) disable iff (rst)
    accept && o_valid && !out_ready |=> s_valid)
    else $error("result of stalled transaction dropped");

endmodule

`default_nettype wire
